FILE: src/bmpblit_pkg.sv
`timescale 1ns / 1ps

package bmpblit_pkg;

  // Default sizes for the top-level parameters.
  localparam int DIM_BITS_DEF  = 12;
  localparam int ADDR_BITS_DEF = 24;

  // Fixed field widths.
  localparam int BYTE_W     = 8;
  localparam int COLOR_W    = 24;
  localparam int OUT_ADDR_W = 24;
  localparam int CFG_DIM_W  = 12;
  localparam int CFG_ORG_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  // Entries in the pixel queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd6;

  // Register values after reset.
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH   = 12'd800;
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT  = 12'd480;
  localparam logic [CFG_DIM_W-1:0] RST_LINE_STRIDE   = 12'd800;
  localparam logic [CFG_DIM_W-1:0] RST_SCREEN_WIDTH  = 12'd800;
  localparam logic [CFG_DIM_W-1:0] RST_SCREEN_HEIGHT = 12'd480;

  typedef struct packed {
    logic [CFG_DIM_W-1:0]        image_width;
    logic [CFG_DIM_W-1:0]        image_height;
    logic signed [CFG_ORG_W-1:0] origin_x;
    logic signed [CFG_ORG_W-1:0] origin_y;
    logic [CFG_DIM_W-1:0]        line_stride;
    logic [CFG_DIM_W-1:0]        screen_width;
    logic [CFG_DIM_W-1:0]        screen_height;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: src/bmpblit_ifs.sv
`timescale 1ns / 1ps

interface bmpblit_in_if;
  logic                          valid;
  logic                          ready;
  logic [bmpblit_pkg::BYTE_W-1:0] data_byte;
  logic                          start_of_image;

  modport source(output valid, output data_byte, output start_of_image, input ready);
  modport sink(input valid, input data_byte, input start_of_image, output ready);
endinterface

interface bmpblit_out_if;
  logic                              valid;
  logic                              ready;
  logic [bmpblit_pkg::OUT_ADDR_W-1:0] fb_address;
  logic [bmpblit_pkg::COLOR_W-1:0]    pixel_color;
  logic                              write_enable;
  logic                              last_pixel;

  modport source(output valid, output fb_address, output pixel_color,
                 output write_enable, output last_pixel, input ready);
  modport sink(input valid, input fb_address, input pixel_color,
               input write_enable, input last_pixel, output ready);
endinterface

interface bmpblit_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bmpblit_pkg::CFG_IDX_W-1:0]  index;
  logic [bmpblit_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: src/bmp24_stream_to_framebuffer_blit.sv
`timescale 1ns / 1ps
// A completed pixel passes the queue, stages A and B and the output register.
// One data byte is taken per cycle while the queue has room; three make a pixel.
// The output register, two back-end stages and a 4-entry pixel queue decouple
// the byte input from output stalls; input stalls only when that queue is full.
// Reset (rst_n low, synchronous): counters cleared, queue and pipeline emptied,
// configuration registers loaded with 800x480 image and screen, origin zero.

module bmp24_stream_to_framebuffer_blit #(
  parameter int DIM_BITS  = bmpblit_pkg::DIM_BITS_DEF,
  parameter int ADDR_BITS = bmpblit_pkg::ADDR_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  bmpblit_in_if.sink    in_ch,
  bmpblit_out_if.source out_ch,
  bmpblit_cfg_if.sink   cfg_ch
);

  localparam int ENTRY_W = bmpblit_pkg::COLOR_W + 2 * DIM_BITS + 1;

  // Configuration registers. Writes must be issued only while the block is idle;
  // the block itself does not enforce this. Both halves read them directly.
  bmpblit_pkg::cfg_t cfg_r, cfg_nxt;

  logic                            in_acc;
  logic                            px_push;
  logic [bmpblit_pkg::COLOR_W-1:0] px_color, q_color;
  logic [DIM_BITS-1:0]             px_col, px_row, q_col, q_row;
  logic                            px_last, q_last;
  logic [ENTRY_W-1:0]              q_push_data, q_pop_data;
  bmpblit_pkg::q_stat_t            q_stat;
  logic                            back_ready;
  logic                            q_pop;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bmpblit_pkg::REG_IMAGE_WIDTH:   cfg_nxt.image_width   = cfg_ch.data[11:0];
        bmpblit_pkg::REG_IMAGE_HEIGHT:  cfg_nxt.image_height  = cfg_ch.data[11:0];
        bmpblit_pkg::REG_ORIGIN_X:      cfg_nxt.origin_x      = $signed(cfg_ch.data);
        bmpblit_pkg::REG_ORIGIN_Y:      cfg_nxt.origin_y      = $signed(cfg_ch.data);
        bmpblit_pkg::REG_LINE_STRIDE:   cfg_nxt.line_stride   = cfg_ch.data[11:0];
        bmpblit_pkg::REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_ch.data[11:0];
        bmpblit_pkg::REG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_ch.data[11:0];
        default: begin
          // An unused index is dropped.
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width   <= bmpblit_pkg::RST_IMAGE_WIDTH;
      cfg_r.image_height  <= bmpblit_pkg::RST_IMAGE_HEIGHT;
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.line_stride   <= bmpblit_pkg::RST_LINE_STRIDE;
      cfg_r.screen_width  <= bmpblit_pkg::RST_SCREEN_WIDTH;
      cfg_r.screen_height <= bmpblit_pkg::RST_SCREEN_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end takes a byte whenever the queue has room for a possible pixel.
  // The byte is not decoded before it is taken, so every byte waits while the
  // queue is full.
  assign in_ch.ready = !q_stat.full;
  assign in_acc      = in_ch.valid && in_ch.ready;

  bmpblit_front #(
    .DIM_BITS(DIM_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .data_byte     (in_ch.data_byte),
    .start_of_image(in_ch.start_of_image),
    .cfg           (cfg_r),
    .px_push       (px_push),
    .px_color      (px_color),
    .px_col        (px_col),
    .px_row        (px_row),
    .px_last       (px_last)
  );

  // Each queue entry holds an assembled pixel with its file column, row and last flag.
  assign q_push_data = {px_color, px_col, px_row, px_last};
  assign {q_color, q_col, q_row, q_last} = q_pop_data;
  assign q_pop = back_ready && !q_stat.empty;

  bmpblit_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(bmpblit_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (px_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .stat     (q_stat)
  );

  // The back end maps the pixel to screen coordinates, clips it, and forms
  // row * stride + column over two stages plus the output register.
  bmpblit_back #(
    .DIM_BITS (DIM_BITS),
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (!q_stat.empty),
    .in_ready (back_ready),
    .in_color (q_color),
    .in_col   (q_col),
    .in_row   (q_row),
    .in_last  (q_last),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_addr (out_ch.fb_address),
    .out_color(out_ch.pixel_color),
    .out_we   (out_ch.write_enable),
    .out_last (out_ch.last_pixel)
  );

`ifndef SYNTHESIS
  // A pixel is never produced while the queue cannot take it.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    px_push |-> !q_stat.full)
    else $error("pixel produced while queue full");

  // A start mark makes the byte a blue byte, so it can never complete a pixel.
  a_start_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.start_of_image) |-> !px_push)
    else $error("pixel completed on start-of-image byte");

  // Nothing is offered in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result offered right after reset");
`endif

endmodule

FILE: src/bmpblit_front.sv
`timescale 1ns / 1ps

module bmpblit_front #(
  parameter int DIM_BITS = bmpblit_pkg::DIM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               acc,
  input  logic [bmpblit_pkg::BYTE_W-1:0]     data_byte,
  input  logic                               start_of_image,
  input  bmpblit_pkg::cfg_t                  cfg,
  output logic                               px_push,
  output logic [bmpblit_pkg::COLOR_W-1:0]    px_color,
  output logic [DIM_BITS-1:0]                px_col,
  output logic [DIM_BITS-1:0]                px_row,
  output logic                               px_last
);

  localparam int CW = ((DIM_BITS > bmpblit_pkg::CFG_DIM_W) ? DIM_BITS :
                       bmpblit_pkg::CFG_DIM_W) + 1;

  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  logic [1:0]          phase_r, phase_nxt, phase_e;
  logic [15:0]         bg_r, bg_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt, col_e;
  logic [DIM_BITS-1:0] row_r, row_nxt, row_e;
  logic [1:0]          pad_r, pad_nxt, pad_e, pad_dec;
  logic                inpad_r, inpad_nxt, inpad_e;
  logic [CW-1:0]       col_inc, row_inc;
  logic                row_end, img_end;

  // A start mark restarts the counters before this byte is looked at.
  assign phase_e = start_of_image ? PH_BLUE : phase_r;
  assign col_e   = start_of_image ? '0 : col_r;
  assign row_e   = start_of_image ? '0 : row_r;
  assign pad_e   = start_of_image ? 2'd0 : pad_r;
  assign inpad_e = start_of_image ? 1'b0 : inpad_r;
  assign pad_dec = pad_e - 2'd1;

  assign col_inc = CW'(col_e) + CW'(1);
  assign row_inc = CW'(row_e) + CW'(1);
  assign row_end = col_inc >= CW'(cfg.image_width);
  assign img_end = row_end && (row_inc >= CW'(cfg.image_height));

  assign px_color = {data_byte, bg_r};
  assign px_col   = col_e;
  assign px_row   = row_e;
  assign px_last  = img_end;

  always_comb begin
    phase_nxt = phase_r;
    bg_nxt    = bg_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pad_nxt   = pad_r;
    inpad_nxt = inpad_r;
    px_push   = 1'b0;
    if (acc) begin
      phase_nxt = phase_e;
      col_nxt   = col_e;
      row_nxt   = row_e;
      pad_nxt   = pad_e;
      inpad_nxt = inpad_e;
      if (inpad_e) begin
        pad_nxt   = pad_dec;
        inpad_nxt = (pad_dec != 2'd0);
      end else begin
        unique case (phase_e)
          PH_BLUE: begin
            bg_nxt    = {8'h00, data_byte};
            phase_nxt = PH_GREEN;
          end
          PH_GREEN: begin
            bg_nxt    = {data_byte, bg_r[7:0]};
            phase_nxt = PH_RED;
          end
          default: begin
            px_push   = 1'b1;
            phase_nxt = PH_BLUE;
            if (row_end) begin
              col_nxt   = '0;
              row_nxt   = img_end ? '0 : row_inc[DIM_BITS-1:0];
              // Three bytes a pixel: the row padding equals width mod 4.
              pad_nxt   = cfg.image_width[1:0];
              inpad_nxt = (cfg.image_width[1:0] != 2'd0);
            end else begin
              col_nxt = col_inc[DIM_BITS-1:0];
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BLUE;
      col_r   <= '0;
      row_r   <= '0;
      pad_r   <= 2'd0;
      inpad_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pad_r   <= pad_nxt;
      inpad_r <= inpad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bg_r <= bg_nxt;
  end

endmodule

FILE: src/bmpblit_queue.sv
`timescale 1ns / 1ps

module bmpblit_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bmpblit_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output bmpblit_pkg::q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == NW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

FILE: src/bmpblit_back.sv
`timescale 1ns / 1ps

module bmpblit_back #(
  parameter int DIM_BITS  = bmpblit_pkg::DIM_BITS_DEF,
  parameter int ADDR_BITS = bmpblit_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bmpblit_pkg::cfg_t                   cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bmpblit_pkg::COLOR_W-1:0]     in_color,
  input  logic [DIM_BITS-1:0]                 in_col,
  input  logic [DIM_BITS-1:0]                 in_row,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bmpblit_pkg::OUT_ADDR_W-1:0]  out_addr,
  output logic [bmpblit_pkg::COLOR_W-1:0]     out_color,
  output logic                                out_we,
  output logic                                out_last
);

  // Signed screen coordinates need room for the origin, the height and the counters.
  localparam int SW = ((DIM_BITS > bmpblit_pkg::CFG_ORG_W) ? DIM_BITS :
                       bmpblit_pkg::CFG_ORG_W) + 2;
  localparam int AW = (ADDR_BITS > bmpblit_pkg::OUT_ADDR_W) ? ADDR_BITS :
                      bmpblit_pkg::OUT_ADDR_W;

  logic signed [SW-1:0] sx, sy;
  logic                 we;

  // Stage A: screen coordinates and clipping.
  logic                            a_v_r;
  logic signed [SW-1:0]            a_sx_r, a_sy_r;
  logic                            a_we_r, a_last_r;
  logic [bmpblit_pkg::COLOR_W-1:0] a_color_r;

  // Stage B: row times stride.
  logic                            b_v_r;
  logic [ADDR_BITS-1:0]            b_prod_r, b_sx_r;
  logic                            b_we_r, b_last_r;
  logic [bmpblit_pkg::COLOR_W-1:0] b_color_r;
  logic [ADDR_BITS-1:0]            sy_a, stride_a;

  // Output register.
  logic                            o_v_r;
  logic [ADDR_BITS-1:0]            addr;
  logic [AW-1:0]                   addr_w;

  logic a_rdy, b_rdy, o_rdy;

  assign o_rdy    = !o_v_r || out_ready;
  assign b_rdy    = !b_v_r || o_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = a_rdy;

  assign sx = SW'(cfg.origin_x) + SW'($signed({1'b0, in_col}));
  assign sy = SW'(cfg.origin_y) + SW'($signed({1'b0, cfg.image_height})) - SW'(1)
              - SW'($signed({1'b0, in_row}));
  assign we = (sx >= SW'(0)) && (sx < SW'($signed({1'b0, cfg.screen_width}))) &&
              (sy >= SW'(0)) && (sy < SW'($signed({1'b0, cfg.screen_height})));

  // Two's complement product: the low address bits are the same for a negative row.
  assign sy_a     = ADDR_BITS'(a_sy_r);
  assign stride_a = ADDR_BITS'(cfg.line_stride);

  assign addr   = b_prod_r + b_sx_r;
  assign addr_w = AW'(addr);

  assign out_valid = o_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_r <= in_valid;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
      if (o_rdy) begin
        o_v_r <= b_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_sx_r    <= sx;
      a_sy_r    <= sy;
      a_we_r    <= we;
      a_last_r  <= in_last;
      a_color_r <= in_color;
    end
    if (b_rdy && a_v_r) begin
      b_prod_r  <= sy_a * stride_a;
      b_sx_r    <= ADDR_BITS'(a_sx_r);
      b_we_r    <= a_we_r;
      b_last_r  <= a_last_r;
      b_color_r <= a_color_r;
    end
    if (o_rdy && b_v_r) begin
      out_addr  <= addr_w[bmpblit_pkg::OUT_ADDR_W-1:0];
      out_color <= b_color_r;
      out_we    <= b_we_r;
      out_last  <= b_last_r;
    end
  end

endmodule

FILE: sim/bmp24_stream_to_framebuffer_blit_tb.sv
`timescale 1ns / 1ps

module bmp24_stream_to_framebuffer_blit_tb;
  import bmpblit_pkg::*;

  // The run is stopped here if the block hangs.
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles allowed after the last expected pixel so that late or spurious
  // pixels still show up before the next register write or the end.
  localparam int DRAIN_CYCLES = 12;
  // The one register index that names no register.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] fb_address;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  write_enable;
    logic                  last_pixel;
  } pixel_t;

  logic clk;
  logic rst_n;

  bmpblit_in_if  in_ch();
  bmpblit_out_if out_ch();
  bmpblit_cfg_if cfg_ch();

  bmp24_stream_to_framebuffer_blit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the registers and of the byte-assembly state of the block.
  cfg_t        blit_cfg;
  logic [1:0]  pix_phase;
  logic [15:0] pix_blue_green;
  logic [11:0] file_col;
  logic [11:0] file_row;
  logic [1:0]  pad_left;
  logic        in_padding;

  // Pixels predicted from accepted bytes, oldest first.
  pixel_t pending_pixels[$];

  // Percentages of cycles in which the byte sender and the pixel receiver idle.
  int send_idle_pct = 17;
  int recv_idle_pct = 57;

  int bytes_sent     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[bmp24_stream_to_framebuffer_blit] ERROR");
    $finish;
  end

  // Prints one line for each mismatch (the first few only) and counts all.
  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    if (mismatch_count < 50)
      $display("mismatch in %s at cycle %0d: got %h, expected %h",
               what, cycle_count, got, want);
    mismatch_count++;
  endtask

  // Computes the effect of one accepted byte. A completed pixel is appended
  // to the queue of pending pixels; every other byte only moves the state.
  function automatic void predict_blit(input logic [7:0] data, input logic sof);
    logic   row_end;
    logic   img_end;
    longint sx;
    longint sy;
    logic [63:0] addr;
    pixel_t px;
    int     pad;
    if (sof) begin
      pix_phase      = 2'd0;
      pix_blue_green = '0;
      file_col       = '0;
      file_row       = '0;
      pad_left       = '0;
      in_padding     = 1'b0;
    end
    if (in_padding) begin
      pad_left = pad_left - 2'd1;
      if (pad_left == 2'd0) in_padding = 1'b0;
      return;
    end
    case (pix_phase)
      2'd0: begin
        pix_blue_green = {8'h00, data};
        pix_phase      = 2'd1;
      end
      2'd1: begin
        pix_blue_green[15:8] = data;
        pix_phase            = 2'd2;
      end
      default: begin
        // Red byte: the pixel is complete.
        pix_phase = 2'd0;
        // A row or the image ends once the counter plus one reaches the
        // register, so a zero register acts like one and a register shrunk
        // below the counter ends the row at once.
        row_end = (int'(file_col) + 1) >= int'(blit_cfg.image_width);
        img_end = row_end && ((int'(file_row) + 1) >= int'(blit_cfg.image_height));
        // The file holds the bottom row first, so rows are flipped.
        sx = longint'($signed(blit_cfg.origin_x)) + longint'(file_col);
        sy = longint'($signed(blit_cfg.origin_y)) + longint'(blit_cfg.image_height)
             - 1 - longint'(file_row);
        // Negative addresses of clipped pixels wrap in two's complement.
        addr = sy * longint'(blit_cfg.line_stride) + sx;
        px.fb_address   = addr[OUT_ADDR_W-1:0];
        px.pixel_color  = {data, pix_blue_green};
        px.write_enable = (sx >= 0) && (sx < longint'(blit_cfg.screen_width)) &&
                          (sy >= 0) && (sy < longint'(blit_cfg.screen_height));
        px.last_pixel   = img_end;
        pending_pixels.push_back(px);
        if (row_end) begin
          file_col   = '0;
          file_row   = img_end ? 12'd0 : file_row + 12'd1;
          // Each file row is padded to a multiple of 4 bytes.
          pad        = (4 - ((int'(blit_cfg.image_width) * 3) & 3)) & 3;
          pad_left   = pad[1:0];
          in_padding = (pad != 0);
        end else begin
          file_col = file_col + 12'd1;
        end
      end
    endcase
  endfunction

  // Offers one byte request and waits until the block takes it. It returns at
  // a falling edge with valid still high, so that a following byte can go out
  // back to back; whoever stops sending lowers valid.
  task automatic send_byte(input logic [7:0] data, input logic sof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= data;
    in_ch.start_of_image <= sof;
    do @(posedge clk); while (!in_ch.ready);
    predict_blit(data, sof);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stops the byte stream and waits until every predicted pixel has come out
  // and the pipeline has had time to settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // One register write request; valid is left high for the caller to lower.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_IMAGE_WIDTH:   blit_cfg.image_width   = value[CFG_DIM_W-1:0];
      REG_IMAGE_HEIGHT:  blit_cfg.image_height  = value[CFG_DIM_W-1:0];
      REG_ORIGIN_X:      blit_cfg.origin_x      = value;
      REG_ORIGIN_Y:      blit_cfg.origin_y      = value;
      REG_LINE_STRIDE:   blit_cfg.line_stride   = value[CFG_DIM_W-1:0];
      REG_SCREEN_WIDTH:  blit_cfg.screen_width  = value[CFG_DIM_W-1:0];
      REG_SCREEN_HEIGHT: blit_cfg.screen_height = value[CFG_DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] width, input logic [CFG_DATA_W-1:0] height,
                          input logic [CFG_DATA_W-1:0] org_x, input logic [CFG_DATA_W-1:0] org_y,
                          input logic [CFG_DATA_W-1:0] stride, input logic [CFG_DATA_W-1:0] scr_w,
                          input logic [CFG_DATA_W-1:0] scr_h);
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_IMAGE_HEIGHT, height);
    write_reg(REG_ORIGIN_X, org_x);
    write_reg(REG_ORIGIN_Y, org_y);
    write_reg(REG_LINE_STRIDE, stride);
    write_reg(REG_SCREEN_WIDTH, scr_w);
    write_reg(REG_SCREEN_HEIGHT, scr_h);
    cfg_ch.valid <= 1'b0;
  endtask

  // A 12-bit size on the 13-bit write bus. The unused top bit is random and
  // must be dropped by the block.
  function automatic logic [CFG_DATA_W-1:0] dim_word(input int v);
    logic [CFG_DATA_W-1:0] w;
    w     = CFG_DATA_W'(v);
    w[12] = 1'($urandom_range(1));
    return w;
  endfunction

  // Sends the bytes of one whole image for the current registers, padding
  // included, with random content. A cut below the full size breaks the
  // image off early.
  task automatic send_image(input int cut);
    int w;
    int row_bytes;
    int total;
    int n;
    w         = int'(blit_cfg.image_width);
    row_bytes = w * 3 + ((4 - ((w * 3) & 3)) & 3);
    total     = int'(blit_cfg.image_height) * row_bytes;
    for (n = 0; n < total && n < cut; n++)
      send_byte(8'($urandom_range(255)), n == 0);
  endtask

  // Each pixel the block hands out is matched against the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", out_ch.fb_address, '0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.fb_address !== want.fb_address)
          report_mismatch("fb_address", out_ch.fb_address, want.fb_address);
        if (out_ch.pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", out_ch.pixel_color, want.pixel_color);
        if (out_ch.write_enable !== want.write_enable)
          report_mismatch("write_enable", 24'(out_ch.write_enable), 24'(want.write_enable));
        if (out_ch.last_pixel !== want.last_pixel)
          report_mismatch("last_pixel", 24'(out_ch.last_pixel), 24'(want.last_pixel));
      end
    end
  end

  // The receiver drops ready at random for the share of cycles given by
  // recv_idle_pct; with a share of zero it always takes pixels.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // A write to the unused index must change nothing, so the first pixel still
  // lands on the bottom row of the default 800x480 screen.
  task automatic test_reset_defaults();
    write_reg(REG_NONE, 13'h1FFF);
    cfg_ch.valid <= 1'b0;
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_idle();
  endtask

  // One pixel per row, so every row carries one padding byte. A start mark
  // on a padding byte abandons the padding, and bytes after the last pixel
  // begin a new image without any mark.
  task automatic test_padding_and_restart();
    set_regs(13'd1, 13'd2, 13'd0, 13'd0, 13'd800, 13'd800, 13'd480);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h88, 1'b0);
    send_byte(8'h99, 1'b0);
    send_byte(8'hAA, 1'b0);
    wait_idle();
  endtask

  // Largest and smallest sizes with the origin at both ends of its range.
  // Both pixels fall off the screen, so only the wrapped address is seen.
  task automatic test_register_extremes();
    set_regs(13'd4095, 13'd4095, 13'h1000, 13'h0FFF, 13'd4095, 13'd4095, 13'd4095);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_idle();
    set_regs(13'd1, 13'd1, 13'h0FFF, 13'h1000, 13'd1, 13'd1, 13'd1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_idle();
  endtask

  // The width drops below the column counter in the middle of a row; the
  // next pixel must end the row.
  task automatic test_width_shrink();
    set_regs(13'd4095, 13'd2, 13'd0, 13'd0, 13'd800, 13'd800, 13'd480);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    cfg_ch.valid <= 1'b0;
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b0);
    wait_idle();
  endtask

  // Width written as zero through a set top bit, height plainly zero: each
  // pixel is a whole image, placed above the screen top.
  task automatic test_zero_dimensions();
    set_regs(13'h1000, 13'd0, 13'd5, 13'h1FFD, 13'd7, 13'd8, 13'd8);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'hEF, 1'b0);
    wait_idle();
  endtask

  // Mostly whole small images with random content, clipped at all four screen
  // edges, some broken off early or followed by stray bytes. The rest is
  // noise under fully random registers, with start marks sprinkled in.
  task automatic test_random_traffic();
    int  mode;
    int  target;
    int  cut;
    int  n;
    int  i;
    bit  wide;
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = bytes_sent + 135;
      while (bytes_sent < target) begin
        wide = ($urandom_range(99) < 15);
        wait_idle();
        if (wide) begin
          set_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom));
          n = $urandom_range(20, 3);
          for (i = 0; i < n; i++)
            send_byte(8'($urandom_range(255)), (i == 0) || ($urandom_range(99) < 15));
        end else begin
          set_regs(dim_word($urandom_range(8, 1)), dim_word($urandom_range(4, 1)),
                   CFG_DATA_W'(int'($urandom_range(12)) - 4),
                   CFG_DATA_W'(int'($urandom_range(10)) - 4),
                   dim_word(($urandom_range(99) < 10) ? 4095 : $urandom_range(16, 1)),
                   dim_word($urandom_range(8, 1)), dim_word($urandom_range(6, 1)));
          cut = ($urandom_range(99) < 15) ? $urandom_range(40, 1) : (1 << 30);
          send_image(cut);
          if ($urandom_range(99) < 30) begin
            n = $urandom_range(6, 1);
            for (i = 0; i < n; i++)
              send_byte(8'($urandom_range(255)), 1'b0);
          end
        end
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.start_of_image = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;

    blit_cfg.image_width   = RST_IMAGE_WIDTH;
    blit_cfg.image_height  = RST_IMAGE_HEIGHT;
    blit_cfg.origin_x      = '0;
    blit_cfg.origin_y      = '0;
    blit_cfg.line_stride   = RST_LINE_STRIDE;
    blit_cfg.screen_width  = RST_SCREEN_WIDTH;
    blit_cfg.screen_height = RST_SCREEN_HEIGHT;
    pix_phase      = 2'd0;
    pix_blue_green = '0;
    file_col       = '0;
    file_row       = '0;
    pad_left       = '0;
    in_padding     = 1'b0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_padding_and_restart();
    test_register_extremes();
    test_width_shrink();
    test_zero_dimensions();
    test_random_traffic();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("[bmp24_stream_to_framebuffer_blit] OK");
    end else begin
      $display("[bmp24_stream_to_framebuffer_blit] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/bmpblit_pkg.sv
src/bmpblit_ifs.sv
src/bmpblit_front.sv
src/bmpblit_queue.sv
src/bmpblit_back.sv
src/bmp24_stream_to_framebuffer_blit.sv
sim/bmp24_stream_to_framebuffer_blit_tb.sv
